// ===== hw/rtl/sitoa_pkg.sv =====
`timescale 1ns / 1ps
// Types, character codes and the divide-by-ten helper for the ASCII decimal converter.
package sitoa_pkg;

  localparam int VALUE_W = 18;
  localparam int CHAR_W  = 8;
  localparam int NUM_POS = 5;
  localparam int DIG_W   = 4;
  localparam int LEN_W   = 3;

  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'd32;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;

  localparam logic [VALUE_W-1:0] DIV10_MUL   = 18'd209716;
  localparam int                 DIV10_SHIFT = 21;
  localparam logic [VALUE_W-1:0] TEN         = 18'd10;

  typedef struct packed {
    logic                          neg;
    logic                          ovf;
    logic [LEN_W-1:0]              len;
    logic [VALUE_W-1:0]            quo;
    logic [NUM_POS-1:0][DIG_W-1:0] dig;
  } stage_t;

  // Exact quotient by ten for every value below 2**18.
  function automatic logic [VALUE_W-1:0] div10(input logic [VALUE_W-1:0] x);
    logic [2*VALUE_W-1:0] p;
    p = x * DIV10_MUL;
    return VALUE_W'(p[2*VALUE_W-1:DIV10_SHIFT]);
  endfunction

endpackage

// ===== hw/rtl/sitoa_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the converter input and result words.
interface sitoa_in_if
  import sitoa_pkg::*;
  ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

interface sitoa_out_if
  import sitoa_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] sign_char;
  logic [CHAR_W-1:0] char_one;
  logic [CHAR_W-1:0] char_two;
  logic [CHAR_W-1:0] char_three;
  logic [CHAR_W-1:0] char_four;
  logic [CHAR_W-1:0] char_five;
  logic              overflow;

  modport source (output valid, output sign_char, output char_one, output char_two,
                  output char_three, output char_four, output char_five,
                  output overflow, input ready);
  modport sink (input valid, input sign_char, input char_one, input char_two,
                input char_three, input char_four, input char_five,
                input overflow, output ready);
endinterface

// ===== hw/rtl/signed_int_to_ascii_decimal_core.sv =====
`timescale 1ns / 1ps
// Pipelined signed integer to six-character ASCII decimal field converter.
//
//   channel  direction  payload
//   in_ch    sink       value (18-bit signed)
//   out_ch   source     sign_char, char_one .. char_five, overflow
//
// One word is accepted per cycle unless a stall on out_ch holds a full pipeline.
// The magnitude stage is loaded at the accepting edge; four divide-by-ten stages, each
// with a constant reciprocal multiplier, and the output register follow it.
// Reset is synchronous and active low and clears only the stage valid bits.
// A stall on out_ch holds each occupied stage with no empty stage after it; empty stages still fill.
module signed_int_to_ascii_decimal_core
  import sitoa_pkg::*;
#(
  parameter int MAX_DIGITS = 5
) (
  input  logic               clk,
  input  logic               rst_n,
  sitoa_in_if.sink           in_ch,
  sitoa_out_if.source        out_ch
);

  localparam int LIMIT = (MAX_DIGITS < NUM_POS) ? MAX_DIGITS : NUM_POS;

  stage_t                    st_r [1:5];
  stage_t                    st_nxt [1:5];
  logic   [5:1]              v_r;
  logic   [6:1]              adv;
  logic                      out_v_r;
  logic   [CHAR_W-1:0]       sign_r, sign_nxt;
  logic   [NUM_POS-1:0][CHAR_W-1:0] chr_r, chr_nxt;
  logic                      ovf_r, ovf_nxt;
  logic   [NUM_POS-1:0][DIG_W-1:0]  digs;
  logic   [LEN_W-1:0]        len1;

  assign adv[6]      = !out_v_r || out_ch.ready;
  assign in_ch.ready = adv[1];

  genvar k;
  generate
    for (k = 1; k <= 5; k++) begin : g_adv
      assign adv[k] = !v_r[k] || adv[k+1];
    end
  endgenerate

  always_comb begin
    st_nxt[1]     = '0;
    st_nxt[1].neg = in_ch.value[VALUE_W-1];
    st_nxt[1].quo = in_ch.value[VALUE_W-1] ? VALUE_W'(~in_ch.value + 1'b1)
                                           : VALUE_W'(in_ch.value);
  end

  always_comb begin
    len1 = LEN_W'(1)
         + LEN_W'(st_r[1].quo >= VALUE_W'(10))
         + LEN_W'(st_r[1].quo >= VALUE_W'(100))
         + LEN_W'(st_r[1].quo >= VALUE_W'(1000))
         + LEN_W'(st_r[1].quo >= VALUE_W'(10000))
         + LEN_W'(st_r[1].quo >= VALUE_W'(100000));
  end

  generate
    for (k = 2; k <= 5; k++) begin : g_div
      logic [VALUE_W-1:0] q;
      logic [VALUE_W-1:0] rem;
      always_comb begin
        q   = div10(st_r[k-1].quo);
        rem = st_r[k-1].quo - VALUE_W'(q * TEN);
        st_nxt[k]          = st_r[k-1];
        st_nxt[k].quo      = q;
        st_nxt[k].dig[k-2] = rem[DIG_W-1:0];
        if (k == 2) begin
          st_nxt[k].len = len1;
          st_nxt[k].ovf = len1 > LEN_W'(LIMIT);
        end
      end
    end
  endgenerate

  always_comb begin
    digs      = st_r[5].dig;
    digs[4]   = st_r[5].quo[DIG_W-1:0];
    ovf_nxt   = st_r[5].ovf;
    sign_nxt  = (st_r[5].neg && !st_r[5].ovf) ? CHAR_MINUS : CHAR_SPACE;
    for (int p = 0; p < NUM_POS; p++) begin
      chr_nxt[p] = CHAR_SPACE;
      if (!st_r[5].ovf && LEN_W'(p) < st_r[5].len) begin
        chr_nxt[p] = CHAR_ZERO + CHAR_W'(digs[LEN_W'(st_r[5].len - LEN_W'(p) - LEN_W'(1))]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r     <= '0;
      out_v_r <= 1'b0;
    end else begin
      if (adv[1]) begin
        v_r[1] <= in_ch.valid;
      end
      for (int s = 2; s <= 5; s++) begin
        if (adv[s]) begin
          v_r[s] <= v_r[s-1];
        end
      end
      if (adv[6]) begin
        out_v_r <= v_r[5];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 1; s <= 5; s++) begin
      if (adv[s]) begin
        st_r[s] <= st_nxt[s];
      end
    end
    if (adv[6]) begin
      sign_r <= sign_nxt;
      chr_r  <= chr_nxt;
      ovf_r  <= ovf_nxt;
    end
  end

  assign out_ch.valid      = out_v_r;
  assign out_ch.sign_char  = sign_r;
  assign out_ch.char_one   = chr_r[0];
  assign out_ch.char_two   = chr_r[1];
  assign out_ch.char_three = chr_r[2];
  assign out_ch.char_four  = chr_r[3];
  assign out_ch.char_five  = chr_r[4];
  assign out_ch.overflow   = ovf_r;

`ifndef SYNTHESIS
  a_ovf_blank: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.overflow |->
      out_ch.sign_char == CHAR_SPACE && out_ch.char_one == CHAR_SPACE &&
      out_ch.char_five == CHAR_SPACE)
    else $error("overflow word carries non-blank characters");

  a_first_digit: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.overflow |-> out_ch.char_one != CHAR_SPACE)
    else $error("converted word has no leading digit");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready && (&v_r) |-> !in_ch.ready)
    else $error("input accepted while the pipeline is full and stalled");
`endif

endmodule
